[hw/rtl/qrs_pkg.sv]
// qrs_pkg: shared types and constants of the quadratic root solver
// no dependencies
`timescale 1ns / 1ps
package qrs_pkg;

  localparam int unsigned COEF_WIDTH_DEF = 16;
  localparam int unsigned FRAC_BITS_DEF  = 16;
  localparam int unsigned ROOT_WIDTH     = 34;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NEG_DISC = 2'd1,
    ST_A_ZERO   = 2'd2
  } status_e;

  localparam logic [1:0] COUNT_NONE = 2'd0;
  localparam logic [1:0] COUNT_TWO  = 2'd2;

  typedef struct packed {
    logic    valid;
    status_e status;
  } ctl_t;

endpackage

[hw/rtl/qrs_front.sv]
// qrs_front: discriminant, status, numerator and divisor setup, two register stages
// depends on qrs_pkg
`timescale 1ns / 1ps
module qrs_front #(
  parameter int unsigned W = qrs_pkg::COEF_WIDTH_DEF,
  parameter int unsigned F = qrs_pkg::FRAC_BITS_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 en_i,
  input  logic                 valid_i,
  input  logic signed [W-1:0]  a_i,
  input  logic signed [W-1:0]  b_i,
  input  logic signed [W-1:0]  c_i,
  output qrs_pkg::ctl_t        ctl_o,
  output logic [2*W:0]         disc_o,
  output logic signed [W+F+2:0] nb_o,
  output logic [W:0]           den_o,
  output logic                 den_neg_o
);
  localparam int unsigned DW = 2 * W + 3;
  localparam int unsigned NW = W + F + 3;

  logic                   v1_q;
  logic signed [W-1:0]    a1_q, b1_q;
  logic signed [2*W-1:0]  bb1_q, ac1_q;

  logic signed [DW-1:0]   bbx, acx, disc;
  logic signed [NW-1:0]   bx;
  logic [W:0]             a2;
  qrs_pkg::ctl_t          ctl_d;

  // products registered before the subtract
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      a1_q  <= a_i;
      b1_q  <= b_i;
      bb1_q <= b_i * b_i;
      ac1_q <= a_i * c_i;
    end
  end

  always_comb begin
    bbx  = {{(DW-2*W){bb1_q[2*W-1]}}, bb1_q};
    acx  = {{(DW-2*W){ac1_q[2*W-1]}}, ac1_q};
    disc = bbx - (acx <<< 2);
    bx   = {{(NW-W){b1_q[W-1]}}, b1_q};
    a2   = {a1_q, 1'b0};
    ctl_d.valid = v1_q;
    if (disc[DW-1]) begin
      ctl_d.status = qrs_pkg::ST_NEG_DISC;
    end else if (a1_q == '0) begin
      ctl_d.status = qrs_pkg::ST_A_ZERO;
    end else begin
      ctl_d.status = qrs_pkg::ST_OK;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_o <= '0;
    end else if (en_i) begin
      ctl_o <= ctl_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      disc_o    <= disc[2*W:0];
      nb_o      <= -(bx <<< F);
      den_o     <= a1_q[W-1] ? (~a2 + 1'b1) : a2;
      den_neg_o <= a1_q[W-1];
    end
  end

endmodule

[hw/rtl/qrs_sqrt_cell.sv]
// qrs_sqrt_cell: one root bit of the digit-by-digit square root
// depends on qrs_pkg
`timescale 1ns / 1ps
module qrs_sqrt_cell #(
  parameter int unsigned RB = 33,
  parameter int unsigned SW = 8
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            en_i,
  input  qrs_pkg::ctl_t   ctl_i,
  input  logic [2*RB-1:0] rad_i,
  input  logic [RB:0]     rem_i,
  input  logic [RB-1:0]   root_i,
  input  logic [SW-1:0]   side_i,
  output qrs_pkg::ctl_t   ctl_o,
  output logic [2*RB-1:0] rad_o,
  output logic [RB:0]     rem_o,
  output logic [RB-1:0]   root_o,
  output logic [SW-1:0]   side_o
);
  logic [RB+2:0] rem_t, trial, diff;
  logic          ge;

  always_comb begin
    rem_t = {rem_i, rad_i[2*RB-1 -: 2]};
    trial = {1'b0, root_i, 2'b01};
    ge    = rem_t >= trial;
    diff  = rem_t - trial;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_o <= '0;
    end else if (en_i) begin
      ctl_o <= ctl_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rad_o  <= {rad_i[2*RB-3:0], 2'b00};
      rem_o  <= ge ? diff[RB:0] : rem_t[RB:0];
      root_o <= {root_i[RB-2:0], ge};
      side_o <= side_i;
    end
  end

endmodule

[hw/rtl/qrs_div_cell.sv]
// qrs_div_cell: one quotient bit of the restoring divide, both roots side by side
// depends on qrs_pkg
`timescale 1ns / 1ps
module qrs_div_cell #(
  parameter int unsigned NM = 34,
  parameter int unsigned MW = 17
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  qrs_pkg::ctl_t ctl_i,
  input  logic [MW-1:0] den_i,
  input  logic [NM-1:0] nq_p_i,
  input  logic [NM-1:0] nq_m_i,
  input  logic [MW-1:0] rem_p_i,
  input  logic [MW-1:0] rem_m_i,
  input  logic          sgn_p_i,
  input  logic          sgn_m_i,
  output qrs_pkg::ctl_t ctl_o,
  output logic [MW-1:0] den_o,
  output logic [NM-1:0] nq_p_o,
  output logic [NM-1:0] nq_m_o,
  output logic [MW-1:0] rem_p_o,
  output logic [MW-1:0] rem_m_o,
  output logic          sgn_p_o,
  output logic          sgn_m_o
);
  logic [MW:0] tp, tm, dx, dp, dm;
  logic        gp, gm;

  always_comb begin
    dx = {1'b0, den_i};
    tp = {rem_p_i, nq_p_i[NM-1]};
    tm = {rem_m_i, nq_m_i[NM-1]};
    gp = tp >= dx;
    gm = tm >= dx;
    dp = tp - dx;
    dm = tm - dx;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_o <= '0;
    end else if (en_i) begin
      ctl_o <= ctl_i;
    end
  end

  // numerator bits shift out the top, quotient bits shift in the bottom
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      den_o   <= den_i;
      nq_p_o  <= {nq_p_i[NM-2:0], gp};
      nq_m_o  <= {nq_m_i[NM-2:0], gm};
      rem_p_o <= gp ? dp[MW-1:0] : tp[MW-1:0];
      rem_m_o <= gm ? dm[MW-1:0] : tm[MW-1:0];
      sgn_p_o <= sgn_p_i;
      sgn_m_o <= sgn_m_i;
    end
  end

endmodule

[hw/rtl/quadratic_root_solver_top.sv]
// quadratic_root_solver_top: pipelined real-root solver, front end, sqrt and divide chains
// depends on qrs_pkg, qrs_front, qrs_sqrt_cell, qrs_div_cell
`timescale 1ns / 1ps
// Usage:
//   input channel in_valid_i / in_stall_o carries coef_a_i, coef_b_i, coef_c_i;
//   output channel out_valid_o / out_stall_i carries status_o, real_root_count_o,
//   root_plus_o and root_minus_o. A beat moves when valid is high and stall low.
//   Every input beat gives exactly one output beat, in order.
//   A set passes the front end, the square root cells, the numerator and sign
//   register, the divide cells and the output register, in that order.
//   Throughput is one beat per cycle when nothing is stalled: each sqrt cell settles
//   one root bit and each divide cell one quotient bit, so a new set enters every cycle.
//   While the output beat is held by out_stall_i the whole pipe freezes and
//   in_stall_o is raised; nothing is dropped.
//   Reset clears all valid flags; the pipe is ready at once after reset.
//   Status ST_OK gives both roots in signed Q17.16 (at the defaults); a
//   negative discriminant or zero leading coefficient give roots of zero.
module quadratic_root_solver_top #(
  parameter int unsigned COEF_WIDTH = qrs_pkg::COEF_WIDTH_DEF,
  parameter int unsigned FRAC_BITS  = qrs_pkg::FRAC_BITS_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic signed [COEF_WIDTH-1:0]        coef_a_i,
  input  logic signed [COEF_WIDTH-1:0]        coef_b_i,
  input  logic signed [COEF_WIDTH-1:0]        coef_c_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic [1:0]                          status_o,
  output logic [1:0]                          real_root_count_o,
  output logic signed [qrs_pkg::ROOT_WIDTH-1:0] root_plus_o,
  output logic signed [qrs_pkg::ROOT_WIDTH-1:0] root_minus_o
);
  localparam int unsigned W  = COEF_WIDTH;
  localparam int unsigned F  = FRAC_BITS;
  localparam int unsigned RB = W + F + 1;
  localparam int unsigned NW = W + F + 3;
  localparam int unsigned NM = NW - 1;
  localparam int unsigned MW = W + 1;
  localparam int unsigned SW = NW + MW + 1;
  localparam int unsigned RW = qrs_pkg::ROOT_WIDTH;
  localparam int unsigned QW = ((NM > RW) ? NM : RW) + 1;

  logic en;
  qrs_pkg::ctl_t out_ctl_q;

  assign en         = !(out_ctl_q.valid && out_stall_i);
  assign in_stall_o = !en;

  // front end
  qrs_pkg::ctl_t          fr_ctl;
  logic [2*W:0]           fr_disc;
  logic signed [NW-1:0]   fr_nb;
  logic [MW-1:0]          fr_den;
  logic                   fr_den_neg;

  qrs_front #(.W(W), .F(F)) u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .en_i      (en),
    .valid_i   (in_valid_i),
    .a_i       (coef_a_i),
    .b_i       (coef_b_i),
    .c_i       (coef_c_i),
    .ctl_o     (fr_ctl),
    .disc_o    (fr_disc),
    .nb_o      (fr_nb),
    .den_o     (fr_den),
    .den_neg_o (fr_den_neg)
  );

  // square root chain
  qrs_pkg::ctl_t   sq_ctl  [0:RB];
  logic [2*RB-1:0] sq_rad  [0:RB];
  logic [RB:0]     sq_rem  [0:RB];
  logic [RB-1:0]   sq_root [0:RB];
  logic [SW-1:0]   sq_side [0:RB];

  assign sq_ctl[0]  = fr_ctl;
  assign sq_rad[0]  = (2*RB)'(fr_disc) << (2*F);
  assign sq_rem[0]  = '0;
  assign sq_root[0] = '0;
  assign sq_side[0] = {fr_nb, fr_den, fr_den_neg};

  for (genvar k = 0; k < RB; k++) begin : g_sqrt
    qrs_sqrt_cell #(.RB(RB), .SW(SW)) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (en),
      .ctl_i  (sq_ctl[k]),
      .rad_i  (sq_rad[k]),
      .rem_i  (sq_rem[k]),
      .root_i (sq_root[k]),
      .side_i (sq_side[k]),
      .ctl_o  (sq_ctl[k+1]),
      .rad_o  (sq_rad[k+1]),
      .rem_o  (sq_rem[k+1]),
      .root_o (sq_root[k+1]),
      .side_o (sq_side[k+1])
    );
  end

  // numerators and signs
  logic signed [NW-1:0] nb_s, num_p, num_m, abs_p, abs_m;
  logic [MW-1:0]        den_s;
  logic                 den_neg_s;

  always_comb begin
    nb_s      = sq_side[RB][SW-1 -: NW];
    den_s     = sq_side[RB][MW:1];
    den_neg_s = sq_side[RB][0];
    num_p     = nb_s + NW'(sq_root[RB]);
    num_m     = nb_s - NW'(sq_root[RB]);
    abs_p     = num_p[NW-1] ? -num_p : num_p;
    abs_m     = num_m[NW-1] ? -num_m : num_m;
  end

  qrs_pkg::ctl_t dv_ctl   [0:NM];
  logic [MW-1:0] dv_den   [0:NM];
  logic [NM-1:0] dv_nq_p  [0:NM];
  logic [NM-1:0] dv_nq_m  [0:NM];
  logic [MW-1:0] dv_rem_p [0:NM];
  logic [MW-1:0] dv_rem_m [0:NM];
  logic          dv_sgn_p [0:NM];
  logic          dv_sgn_m [0:NM];

  qrs_pkg::ctl_t dv0_ctl_q;
  logic [MW-1:0] dv0_den_q;
  logic [NM-1:0] dv0_nq_p_q, dv0_nq_m_q;
  logic          dv0_sgn_p_q, dv0_sgn_m_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dv0_ctl_q <= '0;
    end else if (en) begin
      dv0_ctl_q <= sq_ctl[RB];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      dv0_den_q   <= den_s;
      dv0_nq_p_q  <= abs_p[NM-1:0];
      dv0_nq_m_q  <= abs_m[NM-1:0];
      dv0_sgn_p_q <= num_p[NW-1] ^ den_neg_s;
      dv0_sgn_m_q <= num_m[NW-1] ^ den_neg_s;
    end
  end

  assign dv_ctl[0]   = dv0_ctl_q;
  assign dv_den[0]   = dv0_den_q;
  assign dv_nq_p[0]  = dv0_nq_p_q;
  assign dv_nq_m[0]  = dv0_nq_m_q;
  assign dv_sgn_p[0] = dv0_sgn_p_q;
  assign dv_sgn_m[0] = dv0_sgn_m_q;
  assign dv_rem_p[0] = '0;
  assign dv_rem_m[0] = '0;

  // divide chain
  for (genvar k = 0; k < NM; k++) begin : g_div
    qrs_div_cell #(.NM(NM), .MW(MW)) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .ctl_i   (dv_ctl[k]),
      .den_i   (dv_den[k]),
      .nq_p_i  (dv_nq_p[k]),
      .nq_m_i  (dv_nq_m[k]),
      .rem_p_i (dv_rem_p[k]),
      .rem_m_i (dv_rem_m[k]),
      .sgn_p_i (dv_sgn_p[k]),
      .sgn_m_i (dv_sgn_m[k]),
      .ctl_o   (dv_ctl[k+1]),
      .den_o   (dv_den[k+1]),
      .nq_p_o  (dv_nq_p[k+1]),
      .nq_m_o  (dv_nq_m[k+1]),
      .rem_p_o (dv_rem_p[k+1]),
      .rem_m_o (dv_rem_m[k+1]),
      .sgn_p_o (dv_sgn_p[k+1]),
      .sgn_m_o (dv_sgn_m[k+1])
    );
  end

  // sign, saturate and pack
  function automatic logic [RW-1:0] pack_root(input logic [NM-1:0] mag, input logic neg);
    logic [QW-1:0] magx, lim;
    logic [RW-1:0] low;
    magx = QW'(mag);
    lim  = QW'(1) << (RW - 1);
    low  = magx[RW-1:0];
    if (neg) begin
      pack_root = (magx > lim) ? lim[RW-1:0] : (~low + 1'b1);
    end else begin
      pack_root = (magx > (lim - 1'b1)) ? (lim[RW-1:0] - 1'b1) : low;
    end
  endfunction

  logic [RW-1:0] rp_d, rm_d;
  logic          ok;

  always_comb begin
    ok   = dv_ctl[NM].status == qrs_pkg::ST_OK;
    rp_d = ok ? pack_root(dv_nq_p[NM], dv_sgn_p[NM]) : '0;
    rm_d = ok ? pack_root(dv_nq_m[NM], dv_sgn_m[NM]) : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ctl_q <= '0;
    end else if (en) begin
      out_ctl_q <= dv_ctl[NM];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      root_plus_o  <= rp_d;
      root_minus_o <= rm_d;
    end
  end

  assign out_valid_o       = out_ctl_q.valid;
  assign status_o          = out_ctl_q.status;
  assign real_root_count_o = (out_ctl_q.status == qrs_pkg::ST_NEG_DISC) ?
                             qrs_pkg::COUNT_NONE : qrs_pkg::COUNT_TWO;

`ifndef SYNTHESIS
  a_stall_only_when_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && out_stall_i))
    else $error("input stalled without a held output beat");

  a_zero_roots: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (status_o != qrs_pkg::ST_OK)) |->
    (root_plus_o == '0 && root_minus_o == '0))
    else $error("nonzero root on a failure status");

  a_hold_while_stalled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=>
    (out_valid_o && $stable(status_o) && $stable(root_plus_o) && $stable(root_minus_o)))
    else $error("output beat changed while stalled");
`endif

endmodule

[test/quadratic_root_solver_top_test.sv]
// quadratic_root_solver_top_test: self-checking bench for the quadratic root solver
// depends on qrs_pkg and quadratic_root_solver_top; predicts roots per beat and checks in order
`timescale 1ns / 1ps
module quadratic_root_solver_top_test;

  localparam int unsigned CW = qrs_pkg::COEF_WIDTH_DEF;
  localparam int unsigned FB = qrs_pkg::FRAC_BITS_DEF;
  localparam int unsigned RWT = qrs_pkg::ROOT_WIDTH;
  localparam int unsigned LATENCY = CW + FB + 1 + CW + FB + 2 + 4;
  localparam int unsigned WATCHDOG_LIMIT = 4000;

  typedef struct packed {
    qrs_pkg::status_e    status;
    logic [1:0]          count;
    logic signed [RWT-1:0] plus;
    logic signed [RWT-1:0] minus;
  } roots_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic signed [CW-1:0] coef_a_i = '0, coef_b_i = '0, coef_c_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic [1:0] status_o, real_root_count_o;
  logic signed [RWT-1:0] root_plus_o, root_minus_o;

  roots_t pending_roots[$];
  int unsigned mismatches = 0;
  int unsigned idle_cycles = 0;
  int unsigned send_idle_pct = 0;
  int unsigned stall_pct = 0;

  always #10 clk_i = ~clk_i;

  quadratic_root_solver_top u_dut (.*);

  function automatic logic [63:0] floor_sqrt_fixed(logic [63:0] d);
    logic [63:0] rem, root, trial, pair;
    rem = 0;
    root = 0;
    for (int i = 31 + FB; i >= 0; i--) begin
      pair = (i >= FB) ? ((d >> (2 * (i - FB))) & 64'd3) : 64'd0;
      rem = (rem << 2) | pair;
      root = root << 1;
      trial = (root << 1) | 64'd1;
      if (rem >= trial) begin
        rem = rem - trial;
        root = root | 64'd1;
      end
    end
    return root;
  endfunction

  function automatic logic signed [RWT-1:0] trunc_div(longint num, longint den);
    longint q;
    longint rmax, rmin;
    rmax = (longint'(1) <<< (RWT - 1)) - 1;
    rmin = -rmax - 1;
    q = num / den;
    if (q > rmax) q = rmax;
    if (q < rmin) q = rmin;
    return q[RWT-1:0];
  endfunction

  function automatic roots_t solve_roots(logic signed [CW-1:0] a, logic signed [CW-1:0] b,
                                         logic signed [CW-1:0] c);
    roots_t r;
    longint la, lb, lc, disc, s, nb;
    la = a;
    lb = b;
    lc = c;
    disc = lb * lb - 4 * la * lc;
    r.plus = '0;
    r.minus = '0;
    if (disc < 0) begin
      r.status = qrs_pkg::ST_NEG_DISC;
      r.count = qrs_pkg::COUNT_NONE;
    end else if (la == 0) begin
      r.status = qrs_pkg::ST_A_ZERO;
      r.count = qrs_pkg::COUNT_TWO;
    end else begin
      r.status = qrs_pkg::ST_OK;
      r.count = qrs_pkg::COUNT_TWO;
      s = longint'(floor_sqrt_fixed(disc));
      nb = -lb * (longint'(1) <<< FB);
      r.plus = trunc_div(nb + s, 2 * la);
      r.minus = trunc_div(nb - s, 2 * la);
    end
    return r;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch %s: got %0d expected %0d", what, got, want);
    mismatches++;
  endtask

  // one coefficient beat; holds until accepted, valid stays up into the next beat
  task automatic send_coefs(logic signed [CW-1:0] a, logic signed [CW-1:0] b,
                            logic signed [CW-1:0] c);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    coef_a_i <= a;
    coef_b_i <= b;
    coef_c_i <= c;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    pending_roots.push_back(solve_roots(a, b, c));
  endtask

  task automatic send_random(int unsigned n);
    logic signed [CW-1:0] a, b, c;
    for (int i = 0; i < n; i++) begin
      a = CW'($urandom);
      b = CW'($urandom);
      c = CW'($urandom);
      case ($urandom_range(5))
        0: a = CW'($urandom_range(7) - 3);
        1: begin  // small sets, mostly real roots
          a = CW'($urandom_range(40) - 20);
          b = CW'($urandom_range(400) - 200);
          c = CW'($urandom_range(40) - 20);
        end
        2: c = '0;
        3: a = '0;
        default: ;
      endcase
      send_coefs(a, b, c);
    end
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (pending_roots.size() != 0) @(posedge clk_i);
  endtask

  always @(posedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < stall_pct);
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_roots.size() == 0) begin
        report_mismatch("unexpected beat status", status_o, -1);
      end else begin
        roots_t e;
        e = pending_roots.pop_front();
        if (status_o !== e.status) report_mismatch("status", status_o, e.status);
        if (real_root_count_o !== e.count) report_mismatch("count", real_root_count_o, e.count);
        if (root_plus_o !== e.plus) report_mismatch("root_plus", root_plus_o, e.plus);
        if (root_minus_o !== e.minus) report_mismatch("root_minus", root_minus_o, e.minus);
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  task automatic test_directed();
    send_coefs(1, -3, 2);
    send_coefs(1, 2, 1);
    send_coefs(1, 0, 1);
    send_coefs(0, 5, 7);
    send_coefs(0, -32768, 32767);
    send_coefs(-32768, -32768, -32768);
    send_coefs(32767, 32767, 32767);
    send_coefs(-32768, 32767, 32767);
    send_coefs(32767, -32768, -32768);
    send_coefs(-1, 0, 32767);
    send_coefs(1, -32768, 0);
    send_coefs(1, 32767, -32768);
    send_coefs(-1, 1, 0);
    send_coefs(3, 7, -5);
    send_coefs(-16'sd21846, 16'sh5555, 16'shAAAA);
    send_coefs(0, 0, 0);
    send_coefs(2, 0, 0);
    send_coefs(-2, 1, 3);
  endtask

  task automatic test_idle_free();
    send_idle_pct = 0;
    stall_pct = 0;
    send_random(300);
  endtask

  task automatic test_sender_gaps();
    send_idle_pct = 73;
    stall_pct = 0;
    send_random(200);
    wait_drained();  // sender holds off until the pipe is empty
    send_random(20);
  endtask

  task automatic test_receiver_stalls();
    send_idle_pct = 0;
    stall_pct = 73;
    send_random(200);
  endtask

  task automatic test_both_idle();
    send_idle_pct = 30;
    stall_pct = 30;
    send_random(210);
  endtask

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_idle_free();
    test_sender_gaps();
    test_receiver_stalls();
    test_both_idle();
    stall_pct = 0;
    wait_drained();
    repeat (LATENCY + 10) @(posedge clk_i);
    if (mismatches == 0 && pending_roots.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
